// ===== hdl/grid_vertex_generator_unit_macros.svh =====
// Assertion macros used by the grid vertex generator checker.
// No dependencies; include once per file that asserts.
`ifndef GRID_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define GRID_VERTEX_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GVG_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("grid vertex generator check failed");

// Next-cycle implication, disabled during reset
`define GVG_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("grid vertex generator check failed");

`endif

// ===== hdl/gvg_pkg.sv =====
// Package for the grid vertex generator: widths, register codes, CORDIC table,
// saturation helpers. No dependencies.
package gvg_pkg;

	localparam int MAX_GRID_DEF      = 256;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	// Working widths, sized for grids of up to 256 by 256 vertices
	localparam int DIM_W  = 12;
	localparam int LIN_NW = 29;
	localparam int LIN_QW = 17;
	localparam int SPH_NW = 41;
	localparam int SPH_QW = 33;
	localparam int CORD_W = 31;
	localparam int ANG_W  = 33;

	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 31'sd163008219;

	// Arctangent of 2^-k in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef enum logic [2:0] {
		REG_SPHERE_MODE = 3'd0,
		REG_GRID_COLS   = 3'd1,
		REG_GRID_ROWS   = 3'd2,
		REG_SCALE_X     = 3'd3,
		REG_SCALE_Y     = 3'd4,
		REG_TEX_SCALE_U = 3'd5,
		REG_TEX_SCALE_V = 3'd6,
		REG_FLIP_DIR    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic signed [LIN_QW:0] tu;
		logic signed [LIN_QW:0] px;
		logic signed [LIN_QW:0] py;
		logic signed [LIN_QW:0] tv;
	} lin_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] clamp_q14(input logic signed [31:0] v);
		if (v > 32'sd16384) begin
			return 16'sd16384;
		end else if (v < -32'sd16384) begin
			return -16'sd16384;
		end
		return v[15:0];
	endfunction

endpackage

// ===== hdl/gvg_if.sv =====
// Stream interfaces of the grid vertex generator: index requests and vertices.
// No dependencies.
interface gvg_index_if;
	logic       valid;
	logic       ready;
	logic [7:0] col_index;
	logic [7:0] row_index;

	modport source (output valid, output col_index, output row_index, input ready);
	modport sink   (input valid, input col_index, input row_index, output ready);
endinterface

interface gvg_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic signed [15:0] tex_u;
	logic signed [15:0] tex_v;

	modport source (output valid, output pos_x, output pos_y, output pos_z, output norm_x,
		output norm_y, output norm_z, output tex_u, output tex_v, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, input norm_x,
		input norm_y, input norm_z, input tex_u, input tex_v, output ready);
endinterface

// ===== hdl/gvg_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per item.
// Used by gvg_div; no package dependency.
module gvg_div_cell #(
	parameter int DW = 12,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] den,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] acc_i,
	input  logic          neg_i,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] acc_o,
	output logic          neg_o
);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] acc_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// Bring down the next numerator bit and try the subtract
	always_comb begin
		trial = {rem_i, acc_i[QW-1]};
		diff  = trial - {1'b0, den};
		fits  = (trial >= {1'b0, den});
	end

	// Hand the partial remainder and quotient to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			acc_q <= {acc_i[QW-2:0], fits};
			neg_q <= neg_i;
		end
	end

	assign rem_o = rem_q;
	assign acc_o = acc_q;
	assign neg_o = neg_q;

endmodule

// ===== hdl/gvg_div.sv =====
// Pipelined floor divider built from a chain of gvg_div_cell, one bit per cell.
// Depends on gvg_div_cell. Divisor must be stable while items are in flight.
module gvg_div #(
	parameter int NW = 29,
	parameter int DW = 12,
	parameter int QW = 17
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic        [DW-1:0] den,
	output logic signed [QW:0]   quo
);

	logic [NW-1:0]    mag;
	logic [NW+DW-1:0] mag_ext;
	logic [DW-1:0]    rem_c [QW+1];
	logic [QW-1:0]    acc_c [QW+1];
	logic             neg_c [QW+1];
	logic signed [QW:0] q_pos;

	// Split into sign and magnitude; high bits seed the remainder
	always_comb begin
		mag      = num[NW-1] ? -num : num;
		mag_ext  = {{DW{1'b0}}, mag};
		rem_c[0] = mag_ext[QW +: DW];
		acc_c[0] = mag[QW-1:0];
		neg_c[0] = num[NW-1];
	end

	for (genvar k = 0; k < QW; k++) begin : g_cell
		gvg_div_cell #(.DW(DW), .QW(QW)) u_cell (
			.clk   (clk),
			.en    (en),
			.den   (den),
			.rem_i (rem_c[k]),
			.acc_i (acc_c[k]),
			.neg_i (neg_c[k]),
			.rem_o (rem_c[k+1]),
			.acc_o (acc_c[k+1]),
			.neg_o (neg_c[k+1])
		);
	end

	// Round toward minus infinity for negative numerators
	always_comb begin
		q_pos = $signed({1'b0, acc_c[QW]});
		if (!neg_c[QW]) begin
			quo = q_pos;
		end else if (rem_c[QW] != '0) begin
			quo = ~q_pos;
		end else begin
			quo = -q_pos;
		end
	end

endmodule

// ===== hdl/gvg_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// Depends on gvg_pkg for widths and the arctangent table.
module gvg_cordic_cell #(
	parameter int K = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gvg_pkg::CORD_W-1:0] x_i,
	input  logic signed [gvg_pkg::CORD_W-1:0] y_i,
	input  logic signed [gvg_pkg::ANG_W-1:0]  z_i,
	input  logic                              neg_i,
	output logic signed [gvg_pkg::CORD_W-1:0] x_o,
	output logic signed [gvg_pkg::CORD_W-1:0] y_o,
	output logic signed [gvg_pkg::ANG_W-1:0]  z_o,
	output logic                              neg_o
);

	localparam logic signed [gvg_pkg::ANG_W-1:0] ATAN_K =
		$signed(gvg_pkg::ANG_W'(gvg_pkg::ATAN_TURNS[K]));

	logic signed [gvg_pkg::CORD_W-1:0] x_q;
	logic signed [gvg_pkg::CORD_W-1:0] y_q;
	logic signed [gvg_pkg::ANG_W-1:0]  z_q;
	logic                              neg_q;

	// Rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[gvg_pkg::ANG_W-1]) begin
				x_q <= x_i - (y_i >>> K);
				y_q <= y_i + (x_i >>> K);
				z_q <= z_i - ATAN_K;
			end else begin
				x_q <= x_i + (y_i >>> K);
				y_q <= y_i - (x_i >>> K);
				z_q <= z_i + ATAN_K;
			end
			neg_q <= neg_i;
		end
	end

	assign x_o   = x_q;
	assign y_o   = y_q;
	assign z_o   = z_q;
	assign neg_o = neg_q;

endmodule

// ===== hdl/gvg_cordic.sv =====
// Sine and cosine of a binary angle through a chain of gvg_cordic_cell.
// Depends on gvg_pkg and gvg_cordic_cell.
module gvg_cordic #(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [15:0] cos_o,
	output logic signed [15:0] sin_o
);

	logic signed [gvg_pkg::CORD_W-1:0] x_c [STAGES+1];
	logic signed [gvg_pkg::CORD_W-1:0] y_c [STAGES+1];
	logic signed [gvg_pkg::ANG_W-1:0]  z_c [STAGES+1];
	logic                              neg_c [STAGES+1];
	logic [31:0]                       quarter_sum;
	logic [31:0]                       folded;
	logic signed [gvg_pkg::CORD_W-1:0] x_rnd;
	logic signed [gvg_pkg::CORD_W-1:0] y_rnd;
	logic signed [15:0]                c_mag;
	logic signed [15:0]                s_mag;

	// Fold the angle into the right half-plane, remember the negation
	always_comb begin
		quarter_sum = phase + 32'h4000_0000;
		folded      = quarter_sum[31] ? phase + 32'h8000_0000 : phase;
		x_c[0]      = gvg_pkg::CORDIC_GAIN;
		y_c[0]      = '0;
		z_c[0]      = gvg_pkg::ANG_W'($signed(folded));
		neg_c[0]    = quarter_sum[31];
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_cell
		gvg_cordic_cell #(.K(k)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_i   (x_c[k]),
			.y_i   (y_c[k]),
			.z_i   (z_c[k]),
			.neg_i (neg_c[k]),
			.x_o   (x_c[k+1]),
			.y_o   (y_c[k+1]),
			.z_o   (z_c[k+1]),
			.neg_o (neg_c[k+1])
		);
	end

	// Round to Q1.14, clamp, undo the fold
	always_comb begin
		x_rnd = (x_c[STAGES] + 31'sd8192) >>> 14;
		y_rnd = (y_c[STAGES] + 31'sd8192) >>> 14;
		c_mag = gvg_pkg::clamp_q14(32'(x_rnd));
		s_mag = gvg_pkg::clamp_q14(32'(y_rnd));
		cos_o = neg_c[STAGES] ? -c_mag : c_mag;
		sin_o = neg_c[STAGES] ? -s_mag : s_mag;
	end

	// The residual angle leaves the last cell unused
	logic unused_z;
	assign unused_z = ^z_c[STAGES];

endmodule

// ===== hdl/grid_vertex_generator_unit.sv =====
// Grid vertex generator top level: config registers, divider and CORDIC chains,
// sphere products and output skid. Depends on gvg_pkg, gvg_if, gvg_div, gvg_cordic.
//
// Usage: write the eight registers through cfg_we/cfg_index/cfg_data while the
// block is idle, then stream (col_index, row_index) pairs on index_ch. Each pair
// yields one vertex (position, normal, texture coordinate) on vertex_ch, in order.
// Throughput: one vertex per cycle while vertex_ch does not stall. A vertex passes
// through the index clamp register, the 33-cell azimuth/polar divider chain, the
// CORDIC chain, four product and rounding stages and the output register.
// Reset clears the config registers to defaults (plane, 16 by 16, unit scales) and
// empties the pipeline. When vertex_ch stalls, one more vertex lands in a skid
// register; index_ch.ready then drops and the whole pipeline holds until the
// receiver takes data again.
module grid_vertex_generator_unit #(
	parameter int MAX_GRID      = gvg_pkg::MAX_GRID_DEF,
	parameter int CORDIC_STAGES = gvg_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	gvg_index_if.sink           index_ch,
	gvg_vertex_if.source        vertex_ch
);

	localparam int LC_W   = $clog2(MAX_GRID);
	localparam int STAGES = (CORDIC_STAGES < gvg_pkg::ATAN_ENTRIES) ? CORDIC_STAGES
		: gvg_pkg::ATAN_ENTRIES;
	localparam int DEPTH  = gvg_pkg::SPH_QW + STAGES + 5;
	localparam int LIN_DL = gvg_pkg::SPH_QW + STAGES + 3 - gvg_pkg::LIN_QW;
	localparam int LDW    = LC_W + 2;
	localparam int SDW    = LC_W + 1;

	// Configuration registers
	logic               sphere_mode_q;
	logic [8:0]         grid_cols_q;
	logic [8:0]         grid_rows_q;
	logic signed [15:0] scale_x_q;
	logic signed [15:0] scale_y_q;
	logic signed [15:0] tex_scale_u_q;
	logic signed [15:0] tex_scale_v_q;
	logic               flip_dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_mode_q <= 1'b0;
			grid_cols_q   <= 9'd16;
			grid_rows_q   <= 9'd16;
			scale_x_q     <= 16'sd256;
			scale_y_q     <= 16'sd256;
			tex_scale_u_q <= 16'sd256;
			tex_scale_v_q <= 16'sd256;
			flip_dir_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gvg_pkg::REG_SPHERE_MODE: sphere_mode_q <= cfg_data[0];
				gvg_pkg::REG_GRID_COLS:   grid_cols_q   <= cfg_data[8:0];
				gvg_pkg::REG_GRID_ROWS:   grid_rows_q   <= cfg_data[8:0];
				gvg_pkg::REG_SCALE_X:     scale_x_q     <= cfg_data;
				gvg_pkg::REG_SCALE_Y:     scale_y_q     <= cfg_data;
				gvg_pkg::REG_TEX_SCALE_U: tex_scale_u_q <= cfg_data;
				gvg_pkg::REG_TEX_SCALE_V: tex_scale_v_q <= cfg_data;
				gvg_pkg::REG_FLIP_DIR:    flip_dir_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective grid size: last column and last row
	logic [gvg_pkg::DIM_W-1:0] cols_c;
	logic [gvg_pkg::DIM_W-1:0] rows_c;
	logic [gvg_pkg::DIM_W-1:0] lc_w;
	logic [gvg_pkg::DIM_W-1:0] lr_w;
	logic [LC_W-1:0]           lc;
	logic [LC_W-1:0]           lr;

	always_comb begin
		cols_c = gvg_pkg::DIM_W'(grid_cols_q);
		rows_c = gvg_pkg::DIM_W'(grid_rows_q);
		if (cols_c < gvg_pkg::DIM_W'(2)) cols_c = gvg_pkg::DIM_W'(2);
		if (cols_c > gvg_pkg::DIM_W'(MAX_GRID)) cols_c = gvg_pkg::DIM_W'(MAX_GRID);
		if (rows_c < gvg_pkg::DIM_W'(2)) rows_c = gvg_pkg::DIM_W'(2);
		if (rows_c > gvg_pkg::DIM_W'(MAX_GRID)) rows_c = gvg_pkg::DIM_W'(MAX_GRID);
		lc_w = cols_c - gvg_pkg::DIM_W'(1);
		lr_w = rows_c - gvg_pkg::DIM_W'(1);
		lc   = lc_w[LC_W-1:0];
		lr   = lr_w[LC_W-1:0];
	end

	// Pipeline advance and valid chain
	logic             en;
	logic             in_xfer;
	logic [DEPTH-1:0] vld_q;
	logic             out_vld_q;
	logic             skid_vld_q;

	assign en             = !skid_vld_q;
	assign index_ch.ready = en;
	assign in_xfer        = index_ch.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_xfer};
		end
	end

	// Clamp indices on transfer
	logic [7:0] col_s1;
	logic [7:0] row_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= (gvg_pkg::DIM_W'(index_ch.col_index) > lc_w) ? lc_w[7:0]
				: index_ch.col_index;
			row_s1 <= (gvg_pkg::DIM_W'(index_ch.row_index) > lr_w) ? lr_w[7:0]
				: index_ch.row_index;
		end
	end

	// Numerators and divisors of the exact rational terms
	logic signed [gvg_pkg::LIN_NW-1:0] i_n, j_n, lc_n, lr_n;
	logic signed [gvg_pkg::LIN_NW-1:0] sx_n, sy_n, tsu_n, tsv_n;
	logic signed [gvg_pkg::LIN_NW-1:0] num_tu, num_px, num_py, num_tv;
	logic signed [gvg_pkg::SPH_NW-1:0] num_pa, num_pr;

	always_comb begin
		i_n    = $signed(gvg_pkg::LIN_NW'(col_s1));
		j_n    = $signed(gvg_pkg::LIN_NW'(row_s1));
		lc_n   = $signed(gvg_pkg::LIN_NW'(lc));
		lr_n   = $signed(gvg_pkg::LIN_NW'(lr));
		sx_n   = gvg_pkg::LIN_NW'(scale_x_q);
		sy_n   = gvg_pkg::LIN_NW'(scale_y_q);
		tsu_n  = gvg_pkg::LIN_NW'(tex_scale_u_q);
		tsv_n  = gvg_pkg::LIN_NW'(tex_scale_v_q);
		num_tu = ((tsu_n * i_n) <<< 1) + lc_n;
		num_px = ((sx_n * ((i_n <<< 1) - lc_n)) <<< 1) + (lc_n <<< 1);
		num_py = ((sy_n * (lr_n - (j_n <<< 1))) <<< 1) + (lr_n <<< 1);
		num_tv = ((tsv_n * (sphere_mode_q ? j_n : (lr_n - j_n))) <<< 1) + lr_n;
		num_pa = $signed({1'b0, col_s1, 32'h0} + gvg_pkg::SPH_NW'(lc >> 1));
		num_pr = $signed({1'b0, row_s1, 32'h0} + gvg_pkg::SPH_NW'(lr));
	end

	logic signed [gvg_pkg::LIN_QW:0] q_tu, q_px, q_py, q_tv;
	logic signed [gvg_pkg::SPH_QW:0] q_pa, q_pr;

	gvg_div #(.NW(gvg_pkg::LIN_NW), .DW(LDW), .QW(gvg_pkg::LIN_QW)) u_div_tu (
		.clk(clk), .en(en), .num(num_tu), .den({1'b0, lc, 1'b0}), .quo(q_tu));
	gvg_div #(.NW(gvg_pkg::LIN_NW), .DW(LDW), .QW(gvg_pkg::LIN_QW)) u_div_px (
		.clk(clk), .en(en), .num(num_px), .den({lc, 2'b00}), .quo(q_px));
	gvg_div #(.NW(gvg_pkg::LIN_NW), .DW(LDW), .QW(gvg_pkg::LIN_QW)) u_div_py (
		.clk(clk), .en(en), .num(num_py), .den({lr, 2'b00}), .quo(q_py));
	gvg_div #(.NW(gvg_pkg::LIN_NW), .DW(LDW), .QW(gvg_pkg::LIN_QW)) u_div_tv (
		.clk(clk), .en(en), .num(num_tv), .den({1'b0, lr, 1'b0}), .quo(q_tv));
	gvg_div #(.NW(gvg_pkg::SPH_NW), .DW(SDW), .QW(gvg_pkg::SPH_QW)) u_div_pa (
		.clk(clk), .en(en), .num(num_pa), .den({1'b0, lc}), .quo(q_pa));
	gvg_div #(.NW(gvg_pkg::SPH_NW), .DW(SDW), .QW(gvg_pkg::SPH_QW)) u_div_pr (
		.clk(clk), .en(en), .num(num_pr), .den({lr, 1'b0}), .quo(q_pr));

	// Delay the linear terms to meet the sphere products
	gvg_pkg::lin_t lin_tap_q [LIN_DL];

	always_ff @(posedge clk) begin
		if (en) begin
			lin_tap_q[0] <= '{tu: q_tu, px: q_px, py: q_py, tv: q_tv};
			for (int k = 1; k < LIN_DL; k++) begin
				lin_tap_q[k] <= lin_tap_q[k-1];
			end
		end
	end

	// Sine and cosine of azimuth and polar angle
	logic signed [15:0] ca, sa, cr, sr;

	gvg_cordic #(.STAGES(STAGES)) u_cordic_az (
		.clk(clk), .en(en), .phase(q_pa[31:0]), .cos_o(ca), .sin_o(sa));
	gvg_cordic #(.STAGES(STAGES)) u_cordic_pol (
		.clk(clk), .en(en), .phase(q_pr[31:0]), .cos_o(cr), .sin_o(sr));

	// Sphere products over three stages
	logic signed [15:0] ca_s2, sa_s2, cr_s2, sr_s2;
	logic signed [31:0] sc_s3, ss_s3;
	logic signed [15:0] cr_s3;
	logic signed [16:0] rad_s3;
	logic               sg_neg_s3, sg_zero_s3;
	logic signed [48:0] pxw_s4, pyw_s4;
	logic signed [32:0] pzw_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;
	logic signed [15:0] nxm, nym;

	always_comb begin
		nxm = gvg_pkg::clamp_q14((sc_s3 + 32'sd8192) >>> 14);
		nym = gvg_pkg::clamp_q14((ss_s3 + 32'sd8192) >>> 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s2      <= ca;
			sa_s2      <= sa;
			cr_s2      <= cr;
			sr_s2      <= sr;
			sc_s3      <= 32'(sr_s2) * 32'(ca_s2);
			ss_s3      <= 32'(sr_s2) * 32'(sa_s2);
			cr_s3      <= cr_s2;
			rad_s3     <= flip_dir_q ? -17'(scale_x_q) : 17'(scale_x_q);
			sg_neg_s3  <= scale_x_q[15];
			sg_zero_s3 <= (scale_x_q == 16'sd0);
			pxw_s4     <= 49'(rad_s3) * 49'(sc_s3);
			pyw_s4     <= 49'(rad_s3) * 49'(ss_s3);
			pzw_s4     <= 33'(rad_s3) * 33'(cr_s3);
			nx_s4      <= sg_zero_s3 ? 16'sd0 : (sg_neg_s3 ? -nxm : nxm);
			ny_s4      <= sg_zero_s3 ? 16'sd0 : (sg_neg_s3 ? -nym : nym);
			nz_s4      <= sg_zero_s3 ? 16'sd0 : (sg_neg_s3 ? -cr_s3 : cr_s3);
		end
	end

	// Round, saturate and select by mode
	gvg_pkg::vertex_t vtx_next;
	gvg_pkg::vertex_t vtx_s5;
	gvg_pkg::lin_t    lin_d;

	always_comb begin
		lin_d          = lin_tap_q[LIN_DL-1];
		vtx_next.tex_u = gvg_pkg::sat16(64'(lin_d.tu));
		vtx_next.tex_v = gvg_pkg::sat16(64'(lin_d.tv));
		if (sphere_mode_q) begin
			vtx_next.pos_x  = gvg_pkg::sat16(64'((pxw_s4 + 49'sd134217728) >>> 28));
			vtx_next.pos_y  = gvg_pkg::sat16(64'((pyw_s4 + 49'sd134217728) >>> 28));
			vtx_next.pos_z  = gvg_pkg::sat16(64'((pzw_s4 + 33'sd8192) >>> 14));
			vtx_next.norm_x = nx_s4;
			vtx_next.norm_y = ny_s4;
			vtx_next.norm_z = nz_s4;
		end else begin
			vtx_next.pos_x  = gvg_pkg::sat16(64'(lin_d.px));
			vtx_next.pos_y  = gvg_pkg::sat16(64'(lin_d.py));
			vtx_next.pos_z  = 16'sd0;
			vtx_next.norm_x = 16'sd0;
			vtx_next.norm_y = 16'sd0;
			vtx_next.norm_z = 16'sd16384;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s5 <= vtx_next;
		end
	end

	// Output register with one skid entry
	gvg_pkg::vertex_t out_q;
	gvg_pkg::vertex_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_vld_q && !vertex_ch.ready) begin
				skid_vld_q <= vld_q[DEPTH-1];
			end else begin
				out_vld_q <= vld_q[DEPTH-1];
			end
		end else if (vertex_ch.ready) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_vld_q && !vertex_ch.ready) begin
				skid_q <= vtx_s5;
			end else begin
				out_q <= vtx_s5;
			end
		end else if (vertex_ch.ready) begin
			out_q <= skid_q;
		end
	end

	assign vertex_ch.valid  = out_vld_q;
	assign vertex_ch.pos_x  = out_q.pos_x;
	assign vertex_ch.pos_y  = out_q.pos_y;
	assign vertex_ch.pos_z  = out_q.pos_z;
	assign vertex_ch.norm_x = out_q.norm_x;
	assign vertex_ch.norm_y = out_q.norm_y;
	assign vertex_ch.norm_z = out_q.norm_z;
	assign vertex_ch.tex_u  = out_q.tex_u;
	assign vertex_ch.tex_v  = out_q.tex_v;

endmodule

// ===== hdl/gvg_checker.sv =====
// Port-level checker for the grid vertex generator, bound to the top level.
// Depends on gvg_pkg and grid_vertex_generator_unit_macros.svh.
`include "grid_vertex_generator_unit_macros.svh"

module gvg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [2:0]         cfg_index,
	input logic [15:0]        cfg_data,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] pos_z,
	input logic signed [15:0] norm_x,
	input logic signed [15:0] norm_y,
	input logic signed [15:0] norm_z
);

	logic mode_q;
	logic plane_ok;
	logic norm_ok;

	// Track the mode register as written on the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we && (cfg_index == gvg_pkg::REG_SPHERE_MODE)) begin
			mode_q <= cfg_data[0];
		end
	end

	// Fixed plane fields and normal component range
	assign plane_ok = (pos_z == 16'sd0) && (norm_x == 16'sd0) && (norm_y == 16'sd0)
		&& (norm_z == 16'sd16384);
	assign norm_ok  = (norm_x >= -16'sd16384) && (norm_x <= 16'sd16384)
		&& (norm_y >= -16'sd16384) && (norm_y <= 16'sd16384);

	`GVG_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`GVG_ASSERT_NEXT(a_data_hold, clk, arst_n, out_valid && !out_ready, $stable(norm_x))
	`GVG_ASSERT_NOW(a_plane_fixed, clk, arst_n, out_valid && !mode_q, plane_ok)
	`GVG_ASSERT_NOW(a_norm_range, clk, arst_n, out_valid, norm_ok)

endmodule

bind grid_vertex_generator_unit gvg_checker u_gvg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.out_valid (vertex_ch.valid),
	.out_ready (vertex_ch.ready),
	.pos_z     (vertex_ch.pos_z),
	.norm_x    (vertex_ch.norm_x),
	.norm_y    (vertex_ch.norm_y),
	.norm_z    (vertex_ch.norm_z)
);

// ===== verif/tb_grid_vertex_generator_unit.sv =====
// Testbench for grid_vertex_generator_unit: plane and sphere vertex generation
// checked against an in-bench bit-exact predictor. Depends on gvg_pkg and gvg_if.
module tb_grid_vertex_generator_unit;

	localparam int LATENCY = 54;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	gvg_index_if index_ch ();
	gvg_vertex_if vertex_ch ();

	grid_vertex_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .index_ch(index_ch.sink), .vertex_ch(vertex_ch.source)
	);

	// Predictor copy of the configuration
	logic        m_sphere;
	logic [8:0]  m_cols;
	logic [8:0]  m_rows;
	logic signed [15:0] m_sx, m_sy, m_tu, m_tv;
	logic        m_flip;

	gvg_pkg::vertex_t expected_vertices[$];
	int  errors;
	int  cycles;
	bit  quiet_sink;
	int  drop_rate;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint asr_l(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint div_rnd(longint n, longint d);
		longint nn, dd, q;
		nn = 2 * n + d;
		dd = 2 * d;
		q = nn / dd;
		if ((nn % dd) != 0 && nn < 0) q = q - 1;
		return q;
	endfunction

	function automatic logic signed [15:0] sat_16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint lim_q14(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	// Rotation-mode CORDIC on binary angle, folded to the right half plane
	task automatic sincos(input logic [31:0] phase, output longint c, output longint s);
		logic [31:0] u;
		bit neg;
		longint x, y, z, nx;
		u = phase;
		neg = 0;
		x = 163008219;
		y = 0;
		if (((u + 32'h40000000) & 32'h80000000) != 0) begin
			u = u + 32'h80000000;
			neg = 1;
		end
		z = longint'({32'd0, u ^ 32'h80000000}) - 64'sd2147483648;
		for (int k = 0; k < 16; k++) begin
			if (z >= 0) begin
				nx = x - asr_l(y, k);
				y = y + asr_l(x, k);
				z = z - longint'({32'd0, gvg_pkg::ATAN_TURNS[k]});
			end else begin
				nx = x + asr_l(y, k);
				y = y - asr_l(x, k);
				z = z + longint'({32'd0, gvg_pkg::ATAN_TURNS[k]});
			end
			x = nx;
		end
		x = lim_q14(asr_l(x + 8192, 14));
		y = lim_q14(asr_l(y + 8192, 14));
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	task automatic predict_vertex(input logic [7:0] col, input logic [7:0] row,
			output gvg_pkg::vertex_t v);
		longint lc, lr, i, j, px, py, pz, nx, ny, nz, tu, tv;
		longint ca, sa, cr, sr, rad, sg, sx;
		logic [63:0] pa, pr;
		lc = (m_cols < 2) ? 1 : (m_cols > 256) ? 255 : m_cols - 1;
		lr = (m_rows < 2) ? 1 : (m_rows > 256) ? 255 : m_rows - 1;
		i = (col > lc) ? lc : col;
		j = (row > lr) ? lr : row;
		sx = m_sx;
		tu = div_rnd(longint'(m_tu) * i, lc);
		if (!m_sphere) begin
			px = div_rnd(sx * (2 * i - lc), 2 * lc);
			py = div_rnd(longint'(m_sy) * (lr - 2 * j), 2 * lr);
			pz = 0; nx = 0; ny = 0; nz = 16384;
			tv = div_rnd(longint'(m_tv) * (lr - j), lr);
		end else begin
			pa = ((64'(i) << 32) + 64'(lc / 2)) / 64'(lc);
			pr = ((64'(j) << 32) + 64'(lr)) / 64'(2 * lr);
			sincos(pa[31:0], ca, sa);
			sincos(pr[31:0], cr, sr);
			rad = m_flip ? -sx : sx;
			sg = (sx > 0) ? 1 : (sx < 0) ? -1 : 0;
			px = asr_l(rad * sr * ca + (64'sd1 << 27), 28);
			py = asr_l(rad * sr * sa + (64'sd1 << 27), 28);
			pz = asr_l(rad * cr + 8192, 14);
			nx = sg * lim_q14(asr_l(sr * ca + 8192, 14));
			ny = sg * lim_q14(asr_l(sr * sa + 8192, 14));
			nz = sg * cr;
			tv = div_rnd(longint'(m_tv) * j, lr);
		end
		v.pos_x = sat_16(px); v.pos_y = sat_16(py); v.pos_z = sat_16(pz);
		v.norm_x = sat_16(nx); v.norm_y = sat_16(ny); v.norm_z = sat_16(nz);
		v.tex_u = sat_16(tu); v.tex_v = sat_16(tv);
	endtask

	// Write one register and mirror it in the predictor
	task automatic write_reg(input gvg_pkg::reg_idx_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			gvg_pkg::REG_SPHERE_MODE: m_sphere = value[0];
			gvg_pkg::REG_GRID_COLS:   m_cols = value[8:0];
			gvg_pkg::REG_GRID_ROWS:   m_rows = value[8:0];
			gvg_pkg::REG_SCALE_X:     m_sx = value;
			gvg_pkg::REG_SCALE_Y:     m_sy = value;
			gvg_pkg::REG_TEX_SCALE_U: m_tu = value;
			gvg_pkg::REG_TEX_SCALE_V: m_tv = value;
			gvg_pkg::REG_FLIP_DIR:    m_flip = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic mode, input logic [8:0] cols, input logic [8:0] rows,
			input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] tu,
			input logic [15:0] tv, input logic flip);
		write_reg(gvg_pkg::REG_SPHERE_MODE, {15'd0, mode});
		write_reg(gvg_pkg::REG_GRID_COLS, {7'd0, cols});
		write_reg(gvg_pkg::REG_GRID_ROWS, {7'd0, rows});
		write_reg(gvg_pkg::REG_SCALE_X, sx);
		write_reg(gvg_pkg::REG_SCALE_Y, sy);
		write_reg(gvg_pkg::REG_TEX_SCALE_U, tu);
		write_reg(gvg_pkg::REG_TEX_SCALE_V, tv);
		write_reg(gvg_pkg::REG_FLIP_DIR, {15'd0, flip});
		cfg_we <= 1'b0;
	endtask

	// Send one index pair; hold valid until the transfer
	task automatic send_index(input logic [7:0] col, input logic [7:0] row);
		gvg_pkg::vertex_t v;
		while (!quiet_sink && $urandom_range(99) < drop_rate) begin
			index_ch.valid <= 1'b0;
			@(posedge clk);
		end
		index_ch.valid <= 1'b1;
		index_ch.col_index <= col;
		index_ch.row_index <= row;
		predict_vertex(col, row, v);
		expected_vertices.push_back(v);
		do @(posedge clk); while (!index_ch.ready);
	endtask

	// Drop valid and wait for the pipeline to drain before touching registers
	task automatic drain();
		index_ch.valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Receiver stalls
	always @(posedge clk) begin
		if (!arst_n) vertex_ch.ready <= 1'b0;
		else vertex_ch.ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= drop_rate);
	end

	// Compare each vertex transfer with the oldest prediction
	always @(posedge clk) begin
		gvg_pkg::vertex_t got, want;
		if (arst_n && vertex_ch.valid && vertex_ch.ready) begin
			got = '{vertex_ch.pos_x, vertex_ch.pos_y, vertex_ch.pos_z, vertex_ch.norm_x,
				vertex_ch.norm_y, vertex_ch.norm_z, vertex_ch.tex_u, vertex_ch.tex_v};
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected vertex %h", $realtime, got);
				errors++;
			end else begin
				want = expected_vertices.pop_front();
				if (got != want) begin
					$display("%0t: vertex expected %h actual %h", $realtime, want, got);
					errors++;
				end
			end
		end
	end

	task automatic test_plane_directed();
		set_config(1'b0, 9'd16, 9'd16, 16'd256, 16'd256, 16'd256, 16'd256, 1'b0);
		send_index(8'd0, 8'd0);
		send_index(8'd15, 8'd15);
		send_index(8'd255, 8'd255);
		send_index(8'd7, 8'd200);
		drain();
		// Extreme scales, smallest and clamped grid sizes
		set_config(1'b0, 9'd0, 9'd511, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
		send_index(8'd0, 8'd0);
		send_index(8'd1, 8'd255);
		send_index(8'd200, 8'd128);
		drain();
	endtask

	task automatic test_sphere_directed();
		set_config(1'b1, 9'd256, 9'd2, 16'd256, 16'd0, 16'h8000, 16'h7FFF, 1'b0);
		send_index(8'd0, 8'd0);
		send_index(8'd64, 8'd1);
		send_index(8'd255, 8'd1);
		send_index(8'd128, 8'd0);
		drain();
		// Zero radius gives zero position and normal
		set_config(1'b1, 9'd9, 9'd5, 16'd0, 16'd256, 16'd256, 16'd256, 1'b0);
		send_index(8'd3, 8'd2);
		send_index(8'd8, 8'd4);
		drain();
		// Most negative radius flipped saturates position
		set_config(1'b1, 9'd5, 9'd3, 16'h8000, 16'd256, 16'd256, 16'd256, 1'b1);
		send_index(8'd0, 8'd0);
		send_index(8'd0, 8'd2);
		send_index(8'd2, 8'd1);
		send_index(8'd4, 8'd1);
		send_index(8'd255, 8'd255);
		send_index(8'd1, 8'd1);
		drain();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 10; phase++) begin
			set_config(1'($urandom_range(1)), (phase % 3 == 0) ? 9'($urandom_range(511))
				: 9'($urandom_range(256, 2)), (phase % 4 == 0) ? 9'($urandom_range(511))
				: 9'($urandom_range(256, 2)), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 1'($urandom_range(1)));
			quiet_sink = (phase == 4);
			for (int n = 0; n < 110; n++)
				send_index(8'($urandom), 8'($urandom));
			drain();
			quiet_sink = 0;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		quiet_sink = 0;
		drop_rate = 16;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gvg_pkg::REG_SPHERE_MODE;
		cfg_data = '0;
		index_ch.valid = 1'b0;
		index_ch.col_index = '0;
		index_ch.row_index = '0;
		vertex_ch.ready = 1'b0;
		m_sphere = 0; m_cols = 16; m_rows = 16; m_sx = 256; m_sy = 256;
		m_tu = 256; m_tv = 256; m_flip = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Defaults after reset, no register write yet
		send_index(8'd5, 8'd9);
		drain();
		test_plane_directed();
		test_sphere_directed();
		test_random();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
